// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent on the same edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent is followed by a consequent on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ship_pkg.sv =====
`default_nettype none
package ship_pkg;
  localparam int unsigned NumSetsDef = 2048;
  localparam int unsigned NumWaysDef = 16;
  localparam int unsigned TableEntriesDef = 8192;

  localparam int unsigned SigW = 6;
  localparam int unsigned PcW = 22;
  localparam int unsigned AddrW = 64;
  localparam int unsigned RrpvW = 2;
  localparam logic [RrpvW-1:0] RrpvMax = 2'd3;
  localparam logic [RrpvW-1:0] RrpvMid = 2'd2;
  localparam logic [RrpvW-1:0] RrpvNear = 2'd0;
  localparam logic [6:0] SetHashMask = 7'h7F;

  localparam logic FuncVictim = 1'b0;
  localparam logic FuncUpdate = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;      // capture the input beat
    logic clear;      // write reset values at the sweep index
    logic rd_row;     // read set rows and tables
    logic rd_old;     // read the reuse counter of the old signature
    logic wr_victim;  // write aged row unless a way is at max, load the result
    logic wr_update;  // write the update results
  } ship_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_update;
    logic way_ok;
    logic clear_done;
  } ship_sts_t;

  // Folded pc signature.
  function automatic logic [SigW-1:0] hash_pc(input logic [PcW-1:0] pc);
    logic [PcW-1:0] h;
    h = pc ^ (pc >> 8) ^ (pc >> 16);
    return h[SigW-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== design/ship_rrip_replacement_with_stream_bypass.sv =====
// Channel    | Dir | tdata                                          | tuser
// s_axis     | in  | set[10:0] way[14:11] addr[78:15] pc[100:79]    | [0] func, [1] was_hit
// m_axis     | out | victim_way[3:0]                                | -
// A victim request passes the read and victim-write states; its result is
// registered at the write. An update passes the read, old-counter read and
// write states of the set row memories; one with an out-of-range way ends
// after the read. After reset a clearing pass sweeps max(NUM_SETS,
// TABLE_ENTRIES) indices, rounded up to a power of two, before any accept.
// A result waiting on m_axis_tready holds a later victim request in its write cycle.
`default_nettype none
module ship_rrip_replacement_with_stream_bypass
  import ship_pkg::*;
#(
  parameter int unsigned NUM_SETS = NumSetsDef,
  parameter int unsigned NUM_WAYS = NumWaysDef,
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // set_index, way_index, phys_address, pc_low from bit 0 up; zero pad to 104
  input  wire logic [103:0] s_axis_tdata,
  // func, was_hit from bit 0 up
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // victim_way in bits 3:0, zero pad
  output logic [7:0]        m_axis_tdata
);
  ship_cmd_t cmd;
  ship_sts_t sts;
  logic      in_fire;
  logic      out_busy;
  logic [3:0] victim;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_busy = m_axis_tvalid && !m_axis_tready;
  assign m_axis_tdata = {4'd0, victim};

  ship_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i (in_fire),
    .out_busy_i(out_busy),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .in_ready_o(s_axis_tready)
  );

  ship_dp #(.NumSets(NUM_SETS), .NumWays(NUM_WAYS), .TableEntries(TABLE_ENTRIES)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (s_axis_tuser[0]),
    .set_index_i   (s_axis_tdata[10:0]),
    .way_index_i   (s_axis_tdata[14:11]),
    .phys_address_i(s_axis_tdata[78:15]),
    .pc_low_i      (s_axis_tdata[100:79]),
    .was_hit_i     (s_axis_tuser[1]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .victim_way_o  (victim)
  );
endmodule
`default_nettype wire

// ===== design/ship_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module ship_ctrl
  import ship_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_fire_i,
  input  wire logic      out_busy_i,
  input  ship_sts_t      sts_i,
  output ship_cmd_t      cmd_o,
  output logic           in_ready_o
);
  localparam logic [2:0] StClear  = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StRead   = 3'd2;
  localparam logic [2:0] StOld    = 3'd3;
  localparam logic [2:0] StVictim = 3'd4;
  localparam logic [2:0] StUpdate = 3'd5;

  logic [2:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) state_d = StIdle;
      end
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.latch = in_fire_i;
        if (in_fire_i) state_d = StRead;
      end
      StRead: begin
        cmd_o.rd_row = 1'b1;
        if (!sts_i.is_update) state_d = StVictim;
        else if (!sts_i.way_ok) state_d = StIdle;
        else state_d = StOld;
      end
      StOld: begin
        cmd_o.rd_old = 1'b1;
        state_d = StUpdate;
      end
      StVictim: begin
        // Wait here while the previous result is still not taken.
        if (!out_busy_i) begin
          cmd_o.wr_victim = 1'b1;
          state_d = StIdle;
        end
      end
      StUpdate: begin
        cmd_o.wr_update = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_IMPL(a_accept_idle, clk_i, rst_ni, in_fire_i, state_q == StIdle, "accept outside idle")
  `ASSERT_CLK(a_one_write, clk_i, rst_ni, !(cmd_o.wr_victim && cmd_o.wr_update), "two writes")
  `ASSERT_NEXT(a_old_next, clk_i, rst_ni, state_q == StOld, state_q == StUpdate, "old not updated")
endmodule
`default_nettype wire

// ===== design/ship_dp.sv =====
`default_nettype none
`include "assert_macros.svh"
module ship_dp
  import ship_pkg::*;
#(
  parameter int unsigned NumSets = NumSetsDef,
  parameter int unsigned NumWays = NumWaysDef,
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  ship_cmd_t        cmd_i,
  output ship_sts_t        sts_o,
  input  wire logic        func_i,
  input  wire logic [10:0] set_index_i,
  input  wire logic [3:0]  way_index_i,
  input  wire logic [63:0] phys_address_i,
  input  wire logic [21:0] pc_low_i,
  input  wire logic        was_hit_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [3:0]       victim_way_o
);
  localparam int unsigned SetW = $clog2(NumSets);
  localparam int unsigned WayW = $clog2(NumWays);
  localparam int unsigned TabW = $clog2(TableEntries);
  localparam int unsigned RowW = NumWays * RrpvW;
  localparam int unsigned SRowW = NumWays * SigW;
  localparam int unsigned ClrW = (SetW > TabW) ? SetW : TabW;
  localparam int unsigned SetMod = NumSets;

  typedef logic [RrpvW-1:0] rv_t;

  // Memories: one row per set for values and signatures.
  logic [RowW-1:0]  rv_mem  [NumSets];
  logic [SRowW-1:0] sg_mem  [NumSets];
  logic [1:0]       rc_mem  [TableEntries];
  logic [1:0]       sc_mem  [NumSets];
  logic [AddrW-1:0] pa_mem  [NumSets];
  logic [AddrW-1:0] ps_mem  [NumSets];

  logic [ClrW:0]    clr_q;
  logic             func_q, hit_q, way_ok_q;
  logic [SetW-1:0]  set_q;
  logic [WayW-1:0]  way_q;
  logic [AddrW-1:0] addr_q;
  logic [SigW-1:0]  sig_q;
  logic [RowW-1:0]  rv_row_q;
  logic [SRowW-1:0] sg_row_q;
  logic [1:0]       rc_new_q, rc_old_q, sc_q;
  logic [AddrW-1:0] pa_q, ps_q;
  logic             out_valid_q;
  logic [3:0]       victim_q;

  logic [ClrW-1:0]  clr_idx;
  logic [TabW-1:0]  idx_new, idx_old;
  logic [SigW-1:0]  old_sig;
  logic [AddrW-1:0] stride;
  logic             stride_match;
  logic [1:0]       sc_next;
  logic [RowW-1:0]  rv_aged;
  logic [3:0]       first_way;
  rv_t              top;
  logic [RowW-1:0]  rv_upd;
  logic [SRowW-1:0] sg_upd;
  rv_t              ins_val;

  assign clr_idx = clr_q[ClrW-1:0];

  // Table index from the set and a signature.
  function automatic logic [TabW-1:0] slot(input logic [SetW-1:0] s, input logic [SigW-1:0] g);
    logic [12:0] full;
    full = {s[6:0] & SetHashMask, g};
    return full[TabW-1:0];
  endfunction

  assign idx_new = slot(set_q, sig_q);
  assign old_sig = sg_row_q[way_q*SigW +: SigW];
  assign idx_old = slot(set_q, old_sig);

  // Stride detector on the set's history.
  assign stride = (pa_q == '0) ? '0 : addr_q - pa_q;
  assign stride_match = (pa_q != '0) && (stride != '0) && (stride == ps_q);
  always_comb begin
    sc_next = sc_q;
    if (!hit_q) begin
      if (stride_match) begin
        if (sc_q != 2'd3) sc_next = sc_q + 2'd1;
      end else if (sc_q != 2'd0) begin
        sc_next = sc_q - 2'd1;
      end
    end
  end

  // Victim search and aging of the row.
  always_comb begin
    rv_t v;
    top = '0;
    first_way = '0;
    for (int w = 0; w < NumWays; w++) begin
      v = rv_row_q[w*RrpvW +: RrpvW];
      if (w == 0 || v > top) begin
        top = v;
        first_way = 4'(w);
      end
    end
    for (int w = 0; w < NumWays; w++) begin
      rv_aged[w*RrpvW +: RrpvW] = rv_row_q[w*RrpvW +: RrpvW] + (RrpvMax - top);
    end
  end

  // Insertion value and row merge for updates.
  always_comb begin
    logic [1:0] cnt;
    cnt = rc_new_q;
    if (sc_next >= 2'd2) ins_val = RrpvMax;
    else if (hit_q) ins_val = RrpvNear;
    else begin
      if (idx_old == idx_new && cnt != 2'd0) cnt = cnt - 2'd1;
      ins_val = (cnt >= 2'd2) ? RrpvNear : ((cnt == 2'd1) ? RrpvMid : RrpvMax);
    end
    rv_upd = rv_row_q;
    sg_upd = sg_row_q;
    rv_upd[way_q*RrpvW +: RrpvW] = ins_val;
    sg_upd[way_q*SigW +: SigW] = sig_q;
  end

  // Input capture and memory access.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i;
      hit_q <= was_hit_i;
      set_q <= SetW'({21'd0, set_index_i} % SetMod);
      way_q <= WayW'(way_index_i);
      way_ok_q <= ({28'd0, way_index_i} < NumWays);
      addr_q <= phys_address_i;
      sig_q <= hash_pc(pc_low_i);
    end
    if (cmd_i.clear) begin
      if (clr_idx < NumSets) begin
        rv_mem[clr_idx[SetW-1:0]] <= {NumWays{RrpvMax}};
        sg_mem[clr_idx[SetW-1:0]] <= '0;
        sc_mem[clr_idx[SetW-1:0]] <= '0;
        pa_mem[clr_idx[SetW-1:0]] <= '0;
        ps_mem[clr_idx[SetW-1:0]] <= '0;
      end
      if (clr_idx < TableEntries) rc_mem[clr_idx[TabW-1:0]] <= 2'd1;
    end
    if (cmd_i.rd_row) begin
      rv_row_q <= rv_mem[set_q];
      sg_row_q <= sg_mem[set_q];
      sc_q <= sc_mem[set_q];
      pa_q <= pa_mem[set_q];
      ps_q <= ps_mem[set_q];
      rc_new_q <= rc_mem[slot(set_q, sig_q)];
    end
    if (cmd_i.rd_old) rc_old_q <= rc_mem[idx_old];
    if (cmd_i.wr_victim && top != RrpvMax) rv_mem[set_q] <= rv_aged;
    if (cmd_i.wr_update) begin
      rv_mem[set_q] <= rv_upd;
      sg_mem[set_q] <= sg_upd;
      if (!hit_q) begin
        sc_mem[set_q] <= sc_next;
        pa_mem[set_q] <= addr_q;
        ps_mem[set_q] <= stride;
      end
      if (sc_next < 2'd2) begin
        if (hit_q) begin
          if (rc_new_q != 2'd3) rc_mem[idx_new] <= rc_new_q + 2'd1;
        end else if (rc_old_q != 2'd0) begin
          rc_mem[idx_old] <= rc_old_q - 2'd1;
        end
      end
    end
    if (cmd_i.wr_victim) victim_q <= first_way;
  end

  // Sweep counter and output flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear && !clr_q[ClrW]) clr_q <= clr_q + 1'b1;
      if (cmd_i.wr_victim) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.is_update = (func_q == FuncUpdate);
  assign sts_o.way_ok = way_ok_q;
  assign sts_o.clear_done = clr_q[ClrW];
  assign out_valid_o = out_valid_q;
  assign victim_way_o = victim_q;

  `ASSERT_IMPL(a_victim_busy, clk_i, rst_ni, cmd_i.wr_victim, !out_valid_q || out_ready_i,
    "result overwritten")
  `ASSERT_IMPL(a_no_clear_op, clk_i, rst_ni, cmd_i.clear, !out_valid_q, "result during sweep")
endmodule
`default_nettype wire
